// File: rtl/core/tbrl_pkg.sv
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared widths and register indexes of the token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

   localparam int DATA_W  = 64;               // timestamps, tokens, rate
   localparam int USE_W   = 32;               // usage fields
   localparam int CNT_W   = 32;               // throttle counter
   localparam int SEL_W   = 2;                // resource select
   localparam int IDX_W   = 2;                // register index
   localparam int ITER_W  = $clog2(DATA_W);   // serial step counter

   // usage is scaled to work units by this shift (0 to 32, never saturates)
   localparam int WORK_SHIFT = 32;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);

   typedef enum logic [IDX_W-1:0] {
      REG_TOKEN_RATE  = 2'd0,
      REG_BURST_LIMIT = 2'd1,
      REG_RES_SELECT  = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

endpackage

// File: rtl/core/tbrl_mul.sv
// ----------------------------------------------------------------------------
// tbrl_mul
// Saturating multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tbrl_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tbrl_pkg::DATA_W-1:0] multiplicand,
   input  logic [tbrl_pkg::DATA_W-1:0] multiplier,
   output logic                        done,
   output logic [tbrl_pkg::DATA_W-1:0] product
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tbrl_pkg::ITER_W-1:0]   cnt_ff, cnt_in;
   logic [tbrl_pkg::DATA_W-1:0]   mcand_ff, mcand_in;
   logic [tbrl_pkg::DATA_W-1:0]   mplier_ff, mplier_in;
   logic [tbrl_pkg::DATA_W-1:0]   acc_ff, acc_in;
   logic                          sat_ff, sat_in;
   logic [tbrl_pkg::DATA_W:0]     sum;

   // acc = 2*acc + (bit ? a : 0); any carry out means the product overflows
   assign sum = {1'b0, acc_ff[tbrl_pkg::DATA_W-2:0], 1'b0}
              + {1'b0, (mplier_ff[tbrl_pkg::DATA_W-1] ? mcand_ff
                                                      : '0)};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      sat_in    = sat_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         acc_in    = '0;
         sat_in    = 1'b0;
      end else if (busy_ff) begin
         acc_in    = sum[tbrl_pkg::DATA_W-1:0];
         sat_in    = sat_ff | acc_ff[tbrl_pkg::DATA_W-1] | sum[tbrl_pkg::DATA_W];
         mplier_in = {mplier_ff[tbrl_pkg::DATA_W-2:0], 1'b0};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == tbrl_pkg::ITER_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      sat_ff    <= sat_in;
   end

   assign done    = done_ff;
   assign product = sat_ff ? '1 : acc_ff;

endmodule

// File: rtl/core/tbrl_div.sv
// ----------------------------------------------------------------------------
// tbrl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbrl_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tbrl_pkg::DATA_W-1:0] dividend,
   input  logic [tbrl_pkg::DATA_W-1:0] divisor,
   output logic                        done,
   output logic [tbrl_pkg::DATA_W-1:0] quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tbrl_pkg::ITER_W-1:0]   cnt_ff, cnt_in;
   logic [tbrl_pkg::DATA_W-1:0]   dsor_ff, dsor_in;
   logic [tbrl_pkg::DATA_W-1:0]   rem_ff, rem_in;
   logic [tbrl_pkg::DATA_W-1:0]   quo_ff, quo_in;
   logic [tbrl_pkg::DATA_W:0]     trial;
   logic [tbrl_pkg::DATA_W:0]     diff;

   // partial remainder takes the next dividend bit from the quotient register
   assign trial = {rem_ff, quo_ff[tbrl_pkg::DATA_W-1]};
   assign diff  = trial - {1'b0, dsor_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dsor_in = dsor_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dsor_in = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (diff[tbrl_pkg::DATA_W]) begin
            rem_in = trial[tbrl_pkg::DATA_W-1:0];
            quo_in = {quo_ff[tbrl_pkg::DATA_W-2:0], 1'b0};
         end else begin
            rem_in = diff[tbrl_pkg::DATA_W-1:0];
            quo_in = {quo_ff[tbrl_pkg::DATA_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tbrl_pkg::ITER_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      dsor_ff <= dsor_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/token_bucket_rate_limiter.sv
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Token bucket accounting: refill by elapsed time, charge usage, throttle.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  one accounting item (timestamp, four usages, child blocked flag),
//         taken when req_valid is high and req_stall low.
//  rsp_*  one result item per request, taken when rsp_valid is high and
//         rsp_stall low; the result sits in an output register.
//  csr_*  register writes (0 token_rate, 1 burst_limit, 2 resource_select),
//         always ready; index 3 is ignored. Write only while idle.
// Flow: one item at a time. Refill uses a bit-serial multiplier; the
//  wakeup time uses a bit-serial divider and is only run for a throttled
//  item with a nonzero rate. rsp_valid rises at the same edge at which the
//  block returns to idle, and the next item can be taken after that edge.
//  req_stall is high from accept until the result is moved to the output
//  register, so a new item can be taken while a result still waits behind
//  rsp_stall.
// A stalled receiver holds the block in its final state until the output
//  register frees up.
// Reset: bucket, last timestamp, throttle count and the configuration registers clear.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tbrl_pkg::DATA_W-1:0]   req_timestamp,
   input  logic [tbrl_pkg::USE_W-1:0]    req_usage_count,
   input  logic [tbrl_pkg::USE_W-1:0]    req_usage_cycles,
   input  logic [tbrl_pkg::USE_W-1:0]    req_usage_packets,
   input  logic [tbrl_pkg::USE_W-1:0]    req_usage_bits,
   input  logic                          req_child_blocked,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_blocked,
   output logic                          rsp_throttled,
   output logic                          rsp_wakeup_valid,
   output logic [tbrl_pkg::DATA_W-1:0]   rsp_wakeup_time,
   output logic [tbrl_pkg::DATA_W-1:0]   rsp_tokens_left,
   output logic [tbrl_pkg::CNT_W-1:0]    rsp_throttle_total,
   // register write port
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tbrl_pkg::IDX_W-1:0]    csr_index,
   input  logic [tbrl_pkg::DATA_W-1:0]   csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,   // refill product in flight
      ST_SUM   = 6'b000100,   // bucket + refill, saturating
      ST_CHECK = 6'b001000,   // compare with charge, update bucket
      ST_DIV   = 6'b010000,   // wakeup quotient in flight
      ST_DONE  = 6'b100000    // waiting for the output register
   } state_type;

   state_type                      state_ff, state_in;

   // configuration
   logic [tbrl_pkg::DATA_W-1:0]    rate_ff, rate_in;
   logic [tbrl_pkg::DATA_W-1:0]    burst_ff, burst_in;
   logic [tbrl_pkg::SEL_W-1:0]     sel_ff, sel_in;

   // persistent state
   logic [tbrl_pkg::DATA_W-1:0]    bucket_ff, bucket_in;
   logic [tbrl_pkg::DATA_W-1:0]    last_ts_ff, last_ts_in;
   logic [tbrl_pkg::CNT_W-1:0]     tcount_ff, tcount_in;

   // per-item working registers
   logic [tbrl_pkg::DATA_W-1:0]    ts_ff, ts_in;
   logic [tbrl_pkg::DATA_W-1:0]    consumed_ff, consumed_in;
   logic [tbrl_pkg::DATA_W-1:0]    tokens_ff, tokens_in;
   logic                           child_ff, child_in;
   logic                           thr_ff, thr_in;
   logic                           wvalid_ff, wvalid_in;
   logic [tbrl_pkg::DATA_W-1:0]    wtime_ff, wtime_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_blocked_ff, rsp_blocked_in;
   logic                           rsp_thr_ff, rsp_thr_in;
   logic                           rsp_wvalid_ff, rsp_wvalid_in;
   logic [tbrl_pkg::DATA_W-1:0]    rsp_wtime_ff, rsp_wtime_in;
   logic [tbrl_pkg::DATA_W-1:0]    rsp_tokens_ff, rsp_tokens_in;
   logic [tbrl_pkg::CNT_W-1:0]     rsp_total_ff, rsp_total_in;

   logic                           req_accept;
   logic                           out_free;
   logic [tbrl_pkg::USE_W-1:0]     usage_sel;
   logic [tbrl_pkg::DATA_W-1:0]    elapsed;
   logic                           mul_done;
   logic [tbrl_pkg::DATA_W-1:0]    refill;
   logic [tbrl_pkg::DATA_W:0]      tok_sum;
   logic                           short;
   logic                           div_start;
   logic                           div_done;
   logic [tbrl_pkg::DATA_W-1:0]    quotient;
   logic [tbrl_pkg::DATA_W-1:0]    rest;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready  = 1'b1;

   // elapsed time wraps modulo 2^64
   assign elapsed = req_timestamp - last_ts_ff;

   always_comb begin
      unique case (sel_ff)
         2'd0:    usage_sel = req_usage_count;
         2'd1:    usage_sel = req_usage_cycles;
         2'd2:    usage_sel = req_usage_packets;
         default: usage_sel = req_usage_bits;
      endcase
   end

   // refill = rate * elapsed, saturating; started at accept
   tbrl_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (req_accept),
      .multiplicand (rate_ff),
      .multiplier   (elapsed),
      .done         (mul_done),
      .product      (refill)
   );

   assign tok_sum   = {1'b0, bucket_ff} + {1'b0, refill};
   assign short     = (tokens_ff < consumed_ff);
   assign rest      = tokens_ff - consumed_ff;
   assign div_start = (state_ff == ST_CHECK) & short & (rate_ff != '0);

   // wakeup delay = (consumed - tokens) / rate
   tbrl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (consumed_ff - tokens_ff),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in    = state_ff;
      rate_in     = rate_ff;
      burst_in    = burst_ff;
      sel_in      = sel_ff;
      bucket_in   = bucket_ff;
      last_ts_in  = last_ts_ff;
      tcount_in   = tcount_ff;
      ts_in       = ts_ff;
      consumed_in = consumed_ff;
      tokens_in   = tokens_ff;
      child_in    = child_ff;
      thr_in      = thr_ff;
      wvalid_in   = wvalid_ff;
      wtime_in    = wtime_ff;

      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_thr_in     = rsp_thr_ff;
      rsp_wvalid_in  = rsp_wvalid_ff;
      rsp_wtime_in   = rsp_wtime_ff;
      rsp_tokens_in  = rsp_tokens_ff;
      rsp_total_in   = rsp_total_ff;

      // register writes
      if (csr_valid) begin
         unique case (tbrl_pkg::reg_index_type'(csr_index))
            tbrl_pkg::REG_TOKEN_RATE:  rate_in  = csr_data;
            tbrl_pkg::REG_BURST_LIMIT: burst_in = csr_data;
            tbrl_pkg::REG_RES_SELECT:  sel_in   = csr_data[tbrl_pkg::SEL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ts_in       = req_timestamp;
               last_ts_in  = req_timestamp;
               child_in    = req_child_blocked;
               // usage is 32 bits, shift at most 32: no saturation possible
               consumed_in = tbrl_pkg::DATA_W'(usage_sel) << tbrl_pkg::WORK_SHIFT;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            tokens_in = tok_sum[tbrl_pkg::DATA_W] ? '1 : tok_sum[tbrl_pkg::DATA_W-1:0];
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            thr_in    = short;
            wvalid_in = 1'b0;
            wtime_in  = '0;
            if (short) begin
               bucket_in = '0;
               if (tcount_ff != '1) begin
                  tcount_in = tcount_ff + 1'b1;
               end
               if (rate_ff != '0) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               bucket_in = (rest < burst_ff) ? rest : burst_ff;
               state_in  = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               wvalid_in = 1'b1;
               wtime_in  = ts_ff + quotient;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_blocked_in = thr_ff | child_ff;
               rsp_thr_in     = thr_ff;
               rsp_wvalid_in  = wvalid_ff;
               rsp_wtime_in   = wtime_ff;
               rsp_tokens_in  = bucket_ff;
               rsp_total_in   = tcount_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= '0;
         burst_ff     <= '0;
         sel_ff       <= '0;
         bucket_ff    <= '0;
         last_ts_ff   <= '0;
         tcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         burst_ff     <= burst_in;
         sel_ff       <= sel_in;
         bucket_ff    <= bucket_in;
         last_ts_ff   <= last_ts_in;
         tcount_ff    <= tcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ts_ff          <= ts_in;
      consumed_ff    <= consumed_in;
      tokens_ff      <= tokens_in;
      child_ff       <= child_in;
      thr_ff         <= thr_in;
      wvalid_ff      <= wvalid_in;
      wtime_ff       <= wtime_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_thr_ff     <= rsp_thr_in;
      rsp_wvalid_ff  <= rsp_wvalid_in;
      rsp_wtime_ff   <= rsp_wtime_in;
      rsp_tokens_ff  <= rsp_tokens_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_blocked        = rsp_blocked_ff;
   assign rsp_throttled      = rsp_thr_ff;
   assign rsp_wakeup_valid   = rsp_wvalid_ff;
   assign rsp_wakeup_time    = rsp_wtime_ff;
   assign rsp_tokens_left    = rsp_tokens_ff;
   assign rsp_throttle_total = rsp_total_ff;

endmodule
